// File: sv/rgbhsv_pkg.sv
package rgbhsv_pkg;

  // Hue scale: one sector is 60 degrees in 1/64 degree units.
  localparam int HUE_SECTOR = 3840;
  localparam int HUE_FULL   = 23040;

  // Saturation full scale.
  localparam int SAT_ONE = 65535;

  // Quotient bits produced by each divider, one per pipeline stage.
  localparam int QUO_BITS = 16;

  // Output modes of the configuration register.
  localparam logic MODE_HSV = 1'b0;
  localparam logic MODE_HSL = 1'b1;

  // Hue sector chosen by the largest channel.
  typedef enum logic [1:0] {
    SECTOR_RED   = 2'd0,
    SECTOR_GREEN = 2'd1,
    SECTOR_BLUE  = 2'd2
  } sector_t;

endpackage

// File: sv/rgbhsv_div.sv
// Pipelined restoring divider: one quotient bit per stage.
// The caller guarantees num < den * 2^QUO_BITS and den > 0.
module rgbhsv_div #(
  parameter int DEN_W = 9,
  parameter int TAG_W = 1
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   in_valid,
  input  logic [DEN_W+rgbhsv_pkg::QUO_BITS-1:0]  num,
  input  logic [DEN_W-1:0]                       den,
  input  logic [TAG_W-1:0]                       tag,
  output logic                                   out_valid,
  output logic [rgbhsv_pkg::QUO_BITS-1:0]        quo,
  output logic [TAG_W-1:0]                       out_tag
);

  localparam int Q     = rgbhsv_pkg::QUO_BITS;
  localparam int NUM_W = DEN_W + Q;

  logic [DEN_W-1:0] rem_q [Q];
  logic [DEN_W-1:0] den_q [Q];
  logic [Q-1:0]     low_q [Q];
  logic [Q-1:0]     quo_q [Q];
  logic [TAG_W-1:0] tag_q [Q];
  logic [Q-1:0]     valid_q;

  for (genvar s = 0; s < Q; s++) begin : g_stage
    logic [DEN_W-1:0] prev_rem;
    logic [DEN_W-1:0] prev_den;
    logic [Q-1:0]     prev_low;
    logic [Q-1:0]     prev_quo;
    logic [TAG_W-1:0] prev_tag;
    logic             prev_valid;
    logic [DEN_W:0]   trial;
    logic             fits;

    // The first stage starts from the high part of the dividend.
    if (s == 0) begin : g_first
      assign prev_rem   = num[NUM_W-1:Q];
      assign prev_den   = den;
      assign prev_low   = num[Q-1:0];
      assign prev_quo   = '0;
      assign prev_tag   = tag;
      assign prev_valid = in_valid;
    end else begin : g_next
      assign prev_rem   = rem_q[s-1];
      assign prev_den   = den_q[s-1];
      assign prev_low   = low_q[s-1];
      assign prev_quo   = quo_q[s-1];
      assign prev_tag   = tag_q[s-1];
      assign prev_valid = valid_q[s-1];
    end

    // Shift in the next dividend bit and subtract if the divisor fits.
    assign trial = {prev_rem, prev_low[Q-1]};
    assign fits  = (trial >= {1'b0, prev_den});

    always_ff @(posedge clk) begin
      if (rst) begin
        valid_q[s] <= 1'b0;
      end else begin
        valid_q[s] <= prev_valid;
      end
      rem_q[s] <= fits ? DEN_W'(trial - {1'b0, prev_den}) : DEN_W'(trial);
      den_q[s] <= prev_den;
      low_q[s] <= {prev_low[Q-2:0], 1'b0};
      quo_q[s] <= {prev_quo[Q-2:0], fits};
      tag_q[s] <= prev_tag;
    end
  end

  assign out_valid = valid_q[Q-1];
  assign quo       = quo_q[Q-1];
  assign out_tag   = tag_q[Q-1];

endmodule

// File: sv/rgb_to_hsv_hsl_converter_core.sv
// RGB to HSV/HSL converter. The block takes one pixel in every clock cycle
// (busy is always low) and marks each result with result_valid for one
// cycle; the receiver must take it then. The pipeline has one stage for
// max/min and sector selection, one stage for the scaling multiplies, 16
// stages of the two bit-per-stage dividers, and one output stage for the
// hue offset. The output_mode register (cfg_data, 0 = HSV, 1 = HSL) is
// sampled as each item enters and should be written only while no item is
// in flight.
module rgb_to_hsv_hsl_converter_core #(
  parameter int CHANNEL_BITS = 8
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  output logic                    busy,
  input  logic [CHANNEL_BITS-1:0] red_in,
  input  logic [CHANNEL_BITS-1:0] green_in,
  input  logic [CHANNEL_BITS-1:0] blue_in,
  input  logic [CHANNEL_BITS-1:0] alpha_in,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic                    cfg_data,
  output logic                    result_valid,
  output logic [14:0]             hue_out,
  output logic [15:0]             saturation_out,
  output logic [CHANNEL_BITS:0]   level_out,
  output logic [CHANNEL_BITS-1:0] alpha_out
);

  localparam int CB    = CHANNEL_BITS;
  localparam int DEN_W = CB + 1;
  localparam int Q     = rgbhsv_pkg::QUO_BITS;
  localparam int NUM_W = DEN_W + Q;
  localparam logic [CB+1:0] TWO_CMAX = (CB+2)'((2 ** CB - 1) * 2);
  localparam int HTAG_W = 3;
  localparam int STAG_W = 2 * CB + 1;

  // Configuration register.
  logic output_mode;

  assign cfg_ready = 1'b1;
  assign busy      = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      output_mode <= rgbhsv_pkg::MODE_HSV;
    end else if (cfg_valid && cfg_ready) begin
      output_mode <= cfg_data;
    end
  end

  // Stage A: max, min, sector, hue difference and saturation divisor.
  logic [CB-1:0]       mx;
  logic [CB-1:0]       mn;
  logic [CB-1:0]       delta;
  logic [CB:0]         sum;
  logic [CB:0]         other;
  logic [CB:0]         sden;
  logic [CB:0]         diff;
  logic [CB-1:0]       mag;
  rgbhsv_pkg::sector_t sector;

  always_comb begin
    mx = red_in;
    mn = red_in;
    if (green_in > mx) mx = green_in;
    if (blue_in > mx)  mx = blue_in;
    if (green_in < mn) mn = green_in;
    if (blue_in < mn)  mn = blue_in;
    delta = mx - mn;
    sum   = {1'b0, mx} + {1'b0, mn};
    other = (CB+1)'(TWO_CMAX - {1'b0, sum});
    if (output_mode == rgbhsv_pkg::MODE_HSV) begin
      sden = {1'b0, mx};
    end else begin
      sden = (sum < other) ? sum : other;
    end
    // Red wins ties over green, green over blue.
    if (mx == red_in) begin
      sector = rgbhsv_pkg::SECTOR_RED;
      diff   = {1'b0, green_in} - {1'b0, blue_in};
    end else if (mx == green_in) begin
      sector = rgbhsv_pkg::SECTOR_GREEN;
      diff   = {1'b0, blue_in} - {1'b0, red_in};
    end else begin
      sector = rgbhsv_pkg::SECTOR_BLUE;
      diff   = {1'b0, red_in} - {1'b0, green_in};
    end
    mag = diff[CB] ? CB'(-diff) : diff[CB-1:0];
  end

  logic                a_valid;
  logic [CB-1:0]       a_mag;
  logic [DEN_W-1:0]    a_hden;
  logic [CB-1:0]       a_snum;
  logic [DEN_W-1:0]    a_sden;
  logic                a_neg;
  rgbhsv_pkg::sector_t a_sector;
  logic [CB:0]         a_level;
  logic [CB-1:0]       a_alpha;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else begin
      a_valid <= start && !busy;
    end
    // A gray pixel divides zero by one, giving zero hue and saturation.
    if (delta == '0) begin
      a_mag  <= '0;
      a_hden <= DEN_W'(1);
      a_snum <= '0;
      a_sden <= DEN_W'(1);
    end else begin
      a_mag  <= mag;
      a_hden <= {1'b0, delta};
      a_snum <= delta;
      a_sden <= sden;
    end
    a_neg    <= diff[CB] && (delta != '0);
    a_sector <= sector;
    a_level  <= (output_mode == rgbhsv_pkg::MODE_HSV) ? {mx, 1'b0} : sum;
    a_alpha  <= alpha_in;
  end

  // Stage B: scale the dividends.
  logic                b_valid;
  logic [NUM_W-1:0]    b_hnum;
  logic [NUM_W-1:0]    b_snum;
  logic [DEN_W-1:0]    b_hden;
  logic [DEN_W-1:0]    b_sden;
  logic [HTAG_W-1:0]   b_htag;
  logic [STAG_W-1:0]   b_stag;

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else begin
      b_valid <= a_valid;
    end
    b_hnum <= NUM_W'(a_mag) * NUM_W'(rgbhsv_pkg::HUE_SECTOR);
    b_snum <= NUM_W'(a_snum) * NUM_W'(rgbhsv_pkg::SAT_ONE);
    b_hden <= a_hden;
    b_sden <= a_sden;
    b_htag <= {a_neg, a_sector};
    b_stag <= {a_level, a_alpha};
  end

  // Hue and saturation dividers run side by side.
  logic              hq_valid;
  logic              sq_valid;
  logic [Q-1:0]      hquo;
  logic [Q-1:0]      squo;
  logic [HTAG_W-1:0] htag;
  logic [STAG_W-1:0] stag;

  rgbhsv_div #(.DEN_W(DEN_W), .TAG_W(HTAG_W)) u_hue_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (b_valid),
    .num       (b_hnum),
    .den       (b_hden),
    .tag       (b_htag),
    .out_valid (hq_valid),
    .quo       (hquo),
    .out_tag   (htag)
  );

  rgbhsv_div #(.DEN_W(DEN_W), .TAG_W(STAG_W)) u_sat_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (b_valid),
    .num       (b_snum),
    .den       (b_sden),
    .tag       (b_stag),
    .out_valid (sq_valid),
    .quo       (squo),
    .out_tag   (stag)
  );

  // Output stage: add the sector offset and wrap negative hue.
  logic [16:0] hoff;
  logic [16:0] hsum;
  logic [16:0] hwrap;

  always_comb begin
    case (rgbhsv_pkg::sector_t'(htag[1:0]))
      rgbhsv_pkg::SECTOR_RED:   hoff = 17'd0;
      rgbhsv_pkg::SECTOR_GREEN: hoff = 17'(2 * rgbhsv_pkg::HUE_SECTOR);
      rgbhsv_pkg::SECTOR_BLUE:  hoff = 17'(4 * rgbhsv_pkg::HUE_SECTOR);
      default:                  hoff = 17'd0;
    endcase
    hsum  = htag[2] ? (hoff - {1'b0, hquo}) : (hoff + {1'b0, hquo});
    hwrap = hsum[16] ? (hsum + 17'(rgbhsv_pkg::HUE_FULL)) : hsum;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= hq_valid && sq_valid;
    end
    hue_out        <= hwrap[14:0];
    saturation_out <= squo;
    level_out      <= stag[STAG_W-1:CB];
    alpha_out      <= stag[CB-1:0];
  end

endmodule

// File: sv/rgbhsv_checker.sv
// Port-level checks on the converter.
module rgbhsv_checker #(
  parameter int CHANNEL_BITS = 8
) (
  input logic                    clk,
  input logic                    rst,
  input logic                    start,
  input logic                    busy,
  input logic [CHANNEL_BITS-1:0] red_in,
  input logic [CHANNEL_BITS-1:0] green_in,
  input logic [CHANNEL_BITS-1:0] blue_in,
  input logic [CHANNEL_BITS-1:0] alpha_in,
  input logic                    result_valid,
  input logic [14:0]             hue_out,
  input logic [15:0]             saturation_out,
  input logic [CHANNEL_BITS-1:0] alpha_out
);

  localparam int LATENCY = 19;

  // Every accepted item gives a result after the fixed latency.
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##19 result_valid)
    else $error("missing result after accepted item");

  // Alpha comes out with the item it entered with.
  a_alpha: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (alpha_out == $past(alpha_in, LATENCY)))
    else $error("alpha does not match its item");

  // Hue stays within one turn.
  a_hue_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (hue_out < 15'(rgbhsv_pkg::HUE_FULL)))
    else $error("hue out of range");

  // A gray pixel has zero hue and saturation.
  a_gray: assert property (@(posedge clk) disable iff (rst)
    (result_valid && $past(red_in == green_in && green_in == blue_in, LATENCY))
      |-> (hue_out == '0 && saturation_out == '0))
    else $error("gray pixel with nonzero hue or saturation");

endmodule

bind rgb_to_hsv_hsl_converter_core rgbhsv_checker #(.CHANNEL_BITS(CHANNEL_BITS)) u_checker (
  .clk            (clk),
  .rst            (rst),
  .start          (start),
  .busy           (busy),
  .red_in         (red_in),
  .green_in       (green_in),
  .blue_in        (blue_in),
  .alpha_in       (alpha_in),
  .result_valid   (result_valid),
  .hue_out        (hue_out),
  .saturation_out (saturation_out),
  .alpha_out      (alpha_out)
);
